// ----- design/bqc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the cascaded biquad filter: field widths, word types, sequencer
// states and the control struct of the shared multiply-accumulate unit.
// Used by every module of the block; depends on nothing.
package bqc_pkg;

    localparam int COEF_W      = 24;
    localparam int STATE_W     = 40;
    localparam int SAMPLE_W    = 16;
    localparam int SPLIT_W     = 20;
    localparam int PROD_W      = COEF_W + STATE_W;
    localparam int SLOTS       = 5;
    localparam int NSEC_W      = 4;
    localparam int SEC_FIELD_W = 3;
    localparam int SLOT_W      = 3;

    localparam int DEF_MAX_SECTIONS    = 8;
    localparam int DEF_COEF_FRAC_BITS  = 20;
    localparam int DEF_STATE_FRAC_BITS = 16;

    localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

    localparam logic ACT_FILTER = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_W-1:0]    sample_in;
        logic                          block_end;
        logic [SEC_FIELD_W-1:0]        coef_section;
        logic [SLOT_W-1:0]             coef_slot;
        logic signed [COEF_W-1:0]      coef_value;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]    sample_out;
        logic                          clipped;
        logic                          block_end_out;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A1_LO,
        S_A1_HI,
        S_A2_LO,
        S_A2_HI,
        S_W_ACC,
        S_W_SAT,
        S_B0_LO,
        S_B0_HI,
        S_B1_LO,
        S_B1_HI,
        S_B2_LO,
        S_B2_HI,
        S_Y_ACC,
        S_Y_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        mul_op_t mul;
        acc_op_t acc;
    } mac_ctl_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } seq_res_t;

    // Accumulator width: room for the larger of a rounded product and the
    // state word, plus guard bits for three terms.
    function automatic int acc_width(int coef_frac);
        int prod_part;
        prod_part = PROD_W - coef_frac;
        return ((prod_part > STATE_W) ? prod_part : STATE_W) + 3;
    endfunction

endpackage

// ----- design/bqc_coef_mem.sv -----
`timescale 1ns / 1ps
// Coefficient store: five words per section, one write and one registered
// read port, with a valid bit per entry so unwritten words read as zero.
// Depends on bqc_pkg.
module bqc_coef_mem #(
    parameter int MAX_SECTIONS = bqc_pkg::DEF_MAX_SECTIONS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    we,
    input  logic [$clog2(MAX_SECTIONS*bqc_pkg::SLOTS)-1:0] waddr,
    input  logic signed [bqc_pkg::COEF_W-1:0]       wdata,
    input  logic [$clog2(MAX_SECTIONS*bqc_pkg::SLOTS)-1:0] raddr,
    output logic signed [bqc_pkg::COEF_W-1:0]       rdata
);

    localparam int Depth = MAX_SECTIONS * bqc_pkg::SLOTS;

    logic signed [bqc_pkg::COEF_W-1:0] coef_mem [Depth];
    logic [Depth-1:0]                  valid_reg;
    logic                              rvalid_reg;
    logic signed [bqc_pkg::COEF_W-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            coef_mem[waddr] <= wdata;
        end
        rdata_reg <= coef_mem[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ----- design/bqc_mac.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one 24 x 21 multiplier builds each
// coefficient-by-state product in two passes, then rounds it into the sum.
// Depends on bqc_pkg.
module bqc_mac #(
    parameter int COEF_FRAC_BITS = bqc_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                clk,
    input  bqc_pkg::mac_ctl_t                   ctl,
    input  logic signed [bqc_pkg::COEF_W-1:0]   coef,
    input  logic signed [bqc_pkg::STATE_W-1:0]  operand,
    input  logic signed [bqc_pkg::acc_width(COEF_FRAC_BITS)-1:0] load_val,
    output logic signed [bqc_pkg::acc_width(COEF_FRAC_BITS)-1:0] acc
);

    localparam int AccW  = bqc_pkg::acc_width(COEF_FRAC_BITS);
    localparam int ProdW = bqc_pkg::PROD_W;
    localparam int SplW  = bqc_pkg::SPLIT_W;
    localparam int HiW   = bqc_pkg::STATE_W - SplW;
    localparam int MulW  = bqc_pkg::COEF_W + SplW + 1;

    localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(1) << (COEF_FRAC_BITS - 1);

    logic signed [ProdW-1:0] prod_reg, prod_next;
    logic signed [AccW-1:0]  acc_reg, acc_next;
    logic signed [SplW:0]    mul_b;
    logic signed [MulW-1:0]  mul_p;
    logic signed [ProdW-1:0] prod_round;
    logic signed [AccW-1:0]  term;

    // Low pass takes the unsigned low bits, high pass the signed upper bits.
    assign mul_b = (ctl.mul == bqc_pkg::MUL_LO)
                 ? $signed({1'b0, operand[SplW-1:0]})
                 : (SplW+1)'($signed(operand[bqc_pkg::STATE_W-1:SplW]));
    assign mul_p = coef * mul_b;

    assign prod_round = prod_reg >>> COEF_FRAC_BITS;
    assign term       = AccW'(prod_round);

    always_comb
    begin
        unique case (ctl.mul)
            bqc_pkg::MUL_LO: prod_next = ProdW'(mul_p) + RoundHalf;
            bqc_pkg::MUL_HI: prod_next = prod_reg + (ProdW'(mul_p) <<< SplW);
            default:         prod_next = prod_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctl.acc)
            bqc_pkg::ACC_LOAD: acc_next = load_val;
            bqc_pkg::ACC_ADD:  acc_next = acc_reg + term;
            bqc_pkg::ACC_SUB:  acc_next = acc_reg - term;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

    // HiW documents the signed upper half; it must fit the multiplier port.
    if (HiW > SplW + 1)
    begin : g_split_check
        $error("state split does not fit the multiplier operand");
    end

endmodule

// ----- design/bqc_seq.sv -----
`timescale 1ns / 1ps
// Section sequencer: steps the shared MAC through the five products of each
// section, saturates w and y, and holds the per-section delay pairs.
// Depends on bqc_pkg.
module bqc_seq #(
    parameter int MAX_SECTIONS    = bqc_pkg::DEF_MAX_SECTIONS,
    parameter int COEF_FRAC_BITS  = bqc_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_FRAC_BITS = bqc_pkg::DEF_STATE_FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0]    sample,
    input  logic [bqc_pkg::NSEC_W-1:0]             num_sections,
    input  logic                                   out_free,
    input  logic signed [bqc_pkg::acc_width(COEF_FRAC_BITS)-1:0] acc,
    output bqc_pkg::mac_ctl_t                      ctl,
    output logic signed [bqc_pkg::STATE_W-1:0]     operand,
    output logic signed [bqc_pkg::acc_width(COEF_FRAC_BITS)-1:0] load_val,
    output logic [$clog2(MAX_SECTIONS*bqc_pkg::SLOTS)-1:0] raddr,
    output logic                                   busy,
    output bqc_pkg::seq_res_t                      res
);

    localparam int AccW  = bqc_pkg::acc_width(COEF_FRAC_BITS);
    localparam int SecW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int AddrW = $clog2(MAX_SECTIONS * bqc_pkg::SLOTS);
    localparam int StW   = bqc_pkg::STATE_W;
    localparam int SmpW  = bqc_pkg::SAMPLE_W;

    localparam logic signed [AccW-1:0] YHalf     = AccW'(1) << (STATE_FRAC_BITS - 1);
    localparam logic signed [AccW-1:0] TruncBias = (AccW'(1) << STATE_FRAC_BITS) - AccW'(1);
    localparam logic signed [AccW-1:0] WMax      = (AccW'(1) << (StW - 1)) - AccW'(1);
    localparam logic signed [AccW-1:0] WMin      = -(AccW'(1) << (StW - 1));
    localparam logic signed [AccW-1:0] YMax      = (AccW'(1) << (SmpW - 1)) - AccW'(1);
    localparam logic signed [AccW-1:0] YMin      = -(AccW'(1) << (SmpW - 1));

    bqc_pkg::seq_state_t state_reg, state_next;
    logic [SecW-1:0]          sec_reg, sec_next;
    logic [SecW-1:0]          last_reg;
    logic [SecW-1:0]          last_calc;
    logic                     flag_reg;
    logic signed [SmpW-1:0]   x_reg;
    logic signed [StW-1:0]    w_reg;
    logic signed [StW-1:0]    delay1_reg [MAX_SECTIONS];
    logic signed [StW-1:0]    delay2_reg [MAX_SECTIONS];

    logic signed [StW-1:0]    w_sat;
    logic                     w_clip;
    logic signed [AccW-1:0]   y_quot;
    logic signed [SmpW-1:0]   y_sat;
    logic                     y_clip;
    logic                     y_go;
    logic [bqc_pkg::SLOT_W-1:0] slot_next;

    // Zero sections act as one, too many as the full cascade.
    always_comb
    begin
        if (num_sections == '0)
        begin
            last_calc = '0;
        end
        else if (int'(num_sections) > MAX_SECTIONS)
        begin
            last_calc = SecW'(MAX_SECTIONS - 1);
        end
        else
        begin
            last_calc = SecW'(num_sections - 1'b1);
        end
    end

    // w saturates to the state range.
    always_comb
    begin
        w_clip = 1'b1;
        if (acc > WMax)
        begin
            w_sat = WMax[StW-1:0];
        end
        else if (acc < WMin)
        begin
            w_sat = WMin[StW-1:0];
        end
        else
        begin
            w_sat  = acc[StW-1:0];
            w_clip = 1'b0;
        end
    end

    // acc holds y plus one half here: truncate toward zero, then saturate.
    assign y_quot = acc[AccW-1] ? ((acc + TruncBias) >>> STATE_FRAC_BITS)
                                : (acc >>> STATE_FRAC_BITS);

    always_comb
    begin
        y_clip = 1'b1;
        if (y_quot > YMax)
        begin
            y_sat = YMax[SmpW-1:0];
        end
        else if (y_quot < YMin)
        begin
            y_sat = YMin[SmpW-1:0];
        end
        else
        begin
            y_sat  = y_quot[SmpW-1:0];
            y_clip = 1'b0;
        end
    end

    assign y_go = (state_reg == bqc_pkg::S_Y_OUT) && ((sec_reg != last_reg) || out_free);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        sec_next   = sec_reg;
        unique case (state_reg)
            bqc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = bqc_pkg::S_A1_LO;
                    sec_next   = '0;
                end
            end
            bqc_pkg::S_A1_LO: state_next = bqc_pkg::S_A1_HI;
            bqc_pkg::S_A1_HI: state_next = bqc_pkg::S_A2_LO;
            bqc_pkg::S_A2_LO: state_next = bqc_pkg::S_A2_HI;
            bqc_pkg::S_A2_HI: state_next = bqc_pkg::S_W_ACC;
            bqc_pkg::S_W_ACC: state_next = bqc_pkg::S_W_SAT;
            bqc_pkg::S_W_SAT: state_next = bqc_pkg::S_B0_LO;
            bqc_pkg::S_B0_LO: state_next = bqc_pkg::S_B0_HI;
            bqc_pkg::S_B0_HI: state_next = bqc_pkg::S_B1_LO;
            bqc_pkg::S_B1_LO: state_next = bqc_pkg::S_B1_HI;
            bqc_pkg::S_B1_HI: state_next = bqc_pkg::S_B2_LO;
            bqc_pkg::S_B2_LO: state_next = bqc_pkg::S_B2_HI;
            bqc_pkg::S_B2_HI: state_next = bqc_pkg::S_Y_ACC;
            bqc_pkg::S_Y_ACC: state_next = bqc_pkg::S_Y_OUT;
            bqc_pkg::S_Y_OUT:
            begin
                if (sec_reg != last_reg)
                begin
                    state_next = bqc_pkg::S_A1_LO;
                    sec_next   = sec_reg + SecW'(1);
                end
                else if (out_free)
                begin
                    state_next = bqc_pkg::S_IDLE;
                end
            end
            default: state_next = bqc_pkg::S_IDLE;
        endcase
    end

    // MAC control and operand selection
    always_comb
    begin
        ctl.mul  = bqc_pkg::MUL_NONE;
        ctl.acc  = bqc_pkg::ACC_HOLD;
        operand  = delay1_reg[sec_reg];
        load_val = AccW'(x_reg) <<< STATE_FRAC_BITS;
        unique case (state_reg)
            bqc_pkg::S_A1_LO:
            begin
                ctl.mul = bqc_pkg::MUL_LO;
                ctl.acc = bqc_pkg::ACC_LOAD;
            end
            bqc_pkg::S_A1_HI: ctl.mul = bqc_pkg::MUL_HI;
            bqc_pkg::S_A2_LO:
            begin
                ctl.mul = bqc_pkg::MUL_LO;
                ctl.acc = bqc_pkg::ACC_SUB;
                operand = delay2_reg[sec_reg];
            end
            bqc_pkg::S_A2_HI:
            begin
                ctl.mul = bqc_pkg::MUL_HI;
                operand = delay2_reg[sec_reg];
            end
            bqc_pkg::S_W_ACC: ctl.acc = bqc_pkg::ACC_SUB;
            bqc_pkg::S_B0_LO:
            begin
                // start y from one half so rounding costs no extra add
                ctl.mul  = bqc_pkg::MUL_LO;
                ctl.acc  = bqc_pkg::ACC_LOAD;
                operand  = w_reg;
                load_val = YHalf;
            end
            bqc_pkg::S_B0_HI:
            begin
                ctl.mul = bqc_pkg::MUL_HI;
                operand = w_reg;
            end
            bqc_pkg::S_B1_LO:
            begin
                ctl.mul = bqc_pkg::MUL_LO;
                ctl.acc = bqc_pkg::ACC_ADD;
            end
            bqc_pkg::S_B1_HI: ctl.mul = bqc_pkg::MUL_HI;
            bqc_pkg::S_B2_LO:
            begin
                ctl.mul = bqc_pkg::MUL_LO;
                ctl.acc = bqc_pkg::ACC_ADD;
                operand = delay2_reg[sec_reg];
            end
            bqc_pkg::S_B2_HI:
            begin
                ctl.mul = bqc_pkg::MUL_HI;
                operand = delay2_reg[sec_reg];
            end
            bqc_pkg::S_Y_ACC: ctl.acc = bqc_pkg::ACC_ADD;
            default:
            begin
                ctl.mul = bqc_pkg::MUL_NONE;
                ctl.acc = bqc_pkg::ACC_HOLD;
            end
        endcase
    end

    // Address the coefficient from the next state, so the registered read has it ready for the step that needs it.
    always_comb
    begin
        unique case (state_next)
            bqc_pkg::S_A1_LO, bqc_pkg::S_A1_HI: slot_next = bqc_pkg::SLOT_A1;
            bqc_pkg::S_A2_LO, bqc_pkg::S_A2_HI: slot_next = bqc_pkg::SLOT_A2;
            bqc_pkg::S_B1_LO, bqc_pkg::S_B1_HI: slot_next = bqc_pkg::SLOT_B1;
            bqc_pkg::S_B2_LO, bqc_pkg::S_B2_HI: slot_next = bqc_pkg::SLOT_B2;
            default:                            slot_next = bqc_pkg::SLOT_B0;
        endcase
    end

    assign raddr = (AddrW'(sec_next) << 2) + AddrW'(sec_next) + AddrW'(slot_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bqc_pkg::S_IDLE;
            sec_reg   <= '0;
            last_reg  <= '0;
            flag_reg  <= 1'b0;
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                delay1_reg[i] <= '0;
                delay2_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sec_reg   <= sec_next;
            if (start)
            begin
                last_reg <= last_calc;
                flag_reg <= 1'b0;
            end
            else if (state_reg == bqc_pkg::S_W_SAT)
            begin
                flag_reg <= flag_reg | w_clip;
            end
            else if (y_go)
            begin
                flag_reg <= flag_reg | y_clip;
            end
            if (y_go)
            begin
                delay2_reg[sec_reg] <= delay1_reg[sec_reg];
                delay1_reg[sec_reg] <= w_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= sample;
        end
        else if (y_go)
        begin
            x_reg <= y_sat;
        end
        if (state_reg == bqc_pkg::S_W_SAT)
        begin
            w_reg <= w_sat;
        end
    end

    assign busy        = (state_reg != bqc_pkg::S_IDLE);
    assign res.valid   = y_go && (sec_reg == last_reg);
    assign res.sample  = y_sat;
    assign res.clipped = flag_reg | y_clip;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == bqc_pkg::S_IDLE)
        else $error("sample started while a sample is in flight");

    a_sec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != bqc_pkg::S_IDLE |-> sec_reg <= last_reg)
        else $error("section index ran past the last active section");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bqc_pkg::S_Y_OUT && sec_reg == last_reg && !out_free)
        |=> (state_reg == bqc_pkg::S_Y_OUT && $stable(sec_reg)))
        else $error("final step left while the output register was full");

endmodule

// ----- design/biquad_cascade_filter_top.sv -----
`timescale 1ns / 1ps
// Cascaded biquad filter, top level: input decode, section count register,
// output register and the three working parts.
// Depends on bqc_pkg, bqc_coef_mem, bqc_mac and bqc_seq.
//
// Usage:
//   item channel   (item_valid / item_stall / item): each word either writes
//     one coefficient (b0, b1, b2, a1, a2 of a section) or carries a sample.
//   result channel (result_valid / result_stall / result): one word per
//     sample: the output of the last active section, a clip flag and the
//     block_end mark of that sample. Coefficient words give no result.
//   cfg channel    (cfg_valid / cfg_ready / cfg_data): number of active
//     sections; write it only while the filter is idle.
// Operation: a coefficient word is taken whenever the filter is idle. A sample
//   word holds off the next word until it has run through all n active sections:
//   every section runs five products through the one shared multiplier at
//   two passes each, plus accumulate and saturation steps. The result enters
//   the output register at the last step of the last active section.
// Reset: coefficients read as zero, delay state is cleared, one section is
//   active. When the receiver stalls, the result is held; a finishing sample
//   waits in its last step until the output register is free.
module biquad_cascade_filter_top #(
    parameter int MAX_SECTIONS    = bqc_pkg::DEF_MAX_SECTIONS,
    parameter int COEF_FRAC_BITS  = bqc_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_FRAC_BITS = bqc_pkg::DEF_STATE_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  bqc_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output bqc_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bqc_pkg::NSEC_W-1:0]    cfg_data
);

    localparam int AccW  = bqc_pkg::acc_width(COEF_FRAC_BITS);
    localparam int AddrW = $clog2(MAX_SECTIONS * bqc_pkg::SLOTS);

    logic [bqc_pkg::NSEC_W-1:0]          num_sections_reg;
    logic                                result_valid_reg;
    bqc_pkg::result_t                    result_reg;
    logic                                block_end_reg;

    logic                                item_accept;
    logic                                filter_start;
    logic                                coef_we;
    logic [AddrW-1:0]                    coef_waddr;
    logic [AddrW-1:0]                    coef_raddr;
    logic signed [bqc_pkg::COEF_W-1:0]   coef_rdata;
    logic                                busy;
    logic                                out_free;
    bqc_pkg::mac_ctl_t                   mac_ctl;
    logic signed [bqc_pkg::STATE_W-1:0]  mac_operand;
    logic signed [AccW-1:0]              mac_load;
    logic signed [AccW-1:0]              mac_acc;
    bqc_pkg::seq_res_t                   seq_res;

    assign item_stall   = busy;
    assign item_accept  = item_valid && !item_stall;
    assign filter_start = item_accept && (item.action == bqc_pkg::ACT_FILTER);

    // Drop coefficient words addressed outside the table.
    assign coef_we = item_accept && (item.action == bqc_pkg::ACT_COEF)
                  && (item.coef_slot <= bqc_pkg::SLOT_A2)
                  && (int'(item.coef_section) < MAX_SECTIONS);
    assign coef_waddr = (AddrW'(item.coef_section) << 2) + AddrW'(item.coef_section)
                      + AddrW'(item.coef_slot);

    assign out_free  = !result_valid_reg || !result_stall;
    assign cfg_ready = 1'b1;

    bqc_coef_mem #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_coef_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (item.coef_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    bqc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk      (clk),
        .ctl      (mac_ctl),
        .coef     (coef_rdata),
        .operand  (mac_operand),
        .load_val (mac_load),
        .acc      (mac_acc)
    );

    bqc_seq #(
        .MAX_SECTIONS    (MAX_SECTIONS),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS),
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (filter_start),
        .sample       (item.sample_in),
        .num_sections (num_sections_reg),
        .out_free     (out_free),
        .acc          (mac_acc),
        .ctl          (mac_ctl),
        .operand      (mac_operand),
        .load_val     (mac_load),
        .raddr        (coef_raddr),
        .busy         (busy),
        .res          (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_sections_reg <= bqc_pkg::NSEC_W'(1);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_sections_reg <= cfg_data;
            end
            if (seq_res.valid)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (filter_start)
        begin
            block_end_reg <= item.block_end;
        end
        if (seq_res.valid)
        begin
            result_reg.sample_out    <= seq_res.sample;
            result_reg.clipped       <= seq_res.clipped;
            result_reg.block_end_out <= block_end_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        seq_res.valid |-> out_free)
        else $error("result written over a word still waiting");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        filter_start |=> item_stall)
        else $error("item channel open while a sample is being filtered");

endmodule

// ----- dv/biquad_cascade_filter_chk.sv -----
`timescale 1ns / 1ps
// Checker for the cascaded biquad filter: watches the item, result and cfg
// channels, predicts every result word and compares it field by field.
// Depends on bqc_pkg; instantiated beside the block by the testbench top.
module biquad_cascade_filter_chk #(
    parameter int MAX_SECTIONS    = bqc_pkg::DEF_MAX_SECTIONS,
    parameter int COEF_FRAC_BITS  = bqc_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_FRAC_BITS = bqc_pkg::DEF_STATE_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic                       item_stall,
    input  bqc_pkg::item_t             item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  bqc_pkg::result_t           result,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [bqc_pkg::NSEC_W-1:0] cfg_data,
    output int                         fails,
    output int                         pending
);

    localparam longint STATE_MAX = (longint'(1) <<< (bqc_pkg::STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint OUT_MAX   = (longint'(1) <<< (bqc_pkg::SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;
    localparam longint PROD_HALF = longint'(1) <<< (COEF_FRAC_BITS - 1);
    localparam longint OUT_HALF  = longint'(1) <<< (STATE_FRAC_BITS - 1);

    logic signed [bqc_pkg::COEF_W-1:0] coef_words [MAX_SECTIONS*bqc_pkg::SLOTS];
    longint                            w1_state [MAX_SECTIONS];
    longint                            w2_state [MAX_SECTIONS];
    logic [bqc_pkg::NSEC_W-1:0]        active_sections;
    logic                              sat_seen;
    bqc_pkg::result_t                  filtered_q [$];

    // Exact product, then round to state format: add one half, floor.
    function automatic longint coef_product(int idx, longint s);
        longint p;
        p = longint'(coef_words[idx]) * s + PROD_HALF;
        return p >>> COEF_FRAC_BITS;
    endfunction

    function automatic longint run_stage(int k, longint x);
        longint w1, w2, w, y, r;
        int     base;
        base = k * bqc_pkg::SLOTS;
        w1   = w1_state[k];
        w2   = w2_state[k];
        w    = (x <<< STATE_FRAC_BITS) - coef_product(base + int'(bqc_pkg::SLOT_A1), w1)
               - coef_product(base + int'(bqc_pkg::SLOT_A2), w2);
        if (w > STATE_MAX)
        begin
            w = STATE_MAX;
            sat_seen = 1'b1;
        end
        else if (w < STATE_MIN)
        begin
            w = STATE_MIN;
            sat_seen = 1'b1;
        end
        y = coef_product(base + int'(bqc_pkg::SLOT_B0), w)
            + coef_product(base + int'(bqc_pkg::SLOT_B1), w1)
            + coef_product(base + int'(bqc_pkg::SLOT_B2), w2);
        w2_state[k] = w1;
        w1_state[k] = w;
        // add one half, then truncate toward zero
        y = y + OUT_HALF;
        if (y >= 0)
            r = y >>> STATE_FRAC_BITS;
        else
            r = -((-y) >>> STATE_FRAC_BITS);
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
            sat_seen = 1'b1;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
            sat_seen = 1'b1;
        end
        return r;
    endfunction

    function automatic bqc_pkg::result_t filter_sample(bqc_pkg::item_t w);
        bqc_pkg::result_t res;
        longint           x;
        int               n;
        int               k;
        n = int'(active_sections);
        if (n < 1)
            n = 1;
        if (n > MAX_SECTIONS)
            n = MAX_SECTIONS;
        sat_seen = 1'b0;
        x = longint'(w.sample_in);
        for (k = 0; k < n; k++)
            x = run_stage(k, x);
        res.sample_out    = x[bqc_pkg::SAMPLE_W-1:0];
        res.clipped       = sat_seen;
        res.block_end_out = w.block_end;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        bqc_pkg::result_t want;
        int               sec;
        int               slot;
        if (!rst_n)
        begin
            foreach (coef_words[i])
                coef_words[i] = '0;
            foreach (w1_state[i])
            begin
                w1_state[i] = 0;
                w2_state[i] = 0;
            end
            active_sections = bqc_pkg::NSEC_W'(1);
            filtered_q.delete();
            fails   = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    fails++;
                    $error("unexpected result word: sample_out %0d", result.sample_out);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (result.sample_out !== want.sample_out)
                    begin
                        fails++;
                        $error("sample_out: expected %0d, got %0d",
                               want.sample_out, result.sample_out);
                    end
                    if (result.clipped !== want.clipped)
                    begin
                        fails++;
                        $error("clipped: expected %0b, got %0b",
                               want.clipped, result.clipped);
                    end
                    if (result.block_end_out !== want.block_end_out)
                    begin
                        fails++;
                        $error("block_end_out: expected %0b, got %0b",
                               want.block_end_out, result.block_end_out);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.action == bqc_pkg::ACT_COEF)
                begin
                    sec  = int'(item.coef_section);
                    slot = int'(item.coef_slot);
                    // drop writes to a slot or section that does not exist
                    if (slot < bqc_pkg::SLOTS && sec < MAX_SECTIONS)
                        coef_words[sec*bqc_pkg::SLOTS + slot] = item.coef_value;
                end
                else
                begin
                    filtered_q.push_back(filter_sample(item));
                end
            end
            if (cfg_valid && cfg_ready)
                active_sections = cfg_data;
            pending = filtered_q.size();
        end
    end

endmodule

// ----- dv/biquad_cascade_filter_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the cascaded biquad filter: clock, reset, stimulus on the
// item and cfg channels, random stalls on the result channel and the verdict.
// Depends on bqc_pkg, biquad_cascade_filter_top and biquad_cascade_filter_chk.
module biquad_cascade_filter_top_tb;

    localparam int NUM_PHASES    = 10;
    localparam int SAMPLES_PHASE = 120;
    localparam int SETTLE_CYCLES = 14 * bqc_pkg::DEF_MAX_SECTIONS + 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int Q_ONE         = 1 << bqc_pkg::DEF_COEF_FRAC_BITS;
    localparam int C_MAX         = (1 << (bqc_pkg::COEF_W - 1)) - 1;
    localparam int C_MIN         = -(1 << (bqc_pkg::COEF_W - 1));
    localparam int S_MAX         = (1 << (bqc_pkg::SAMPLE_W - 1)) - 1;
    localparam int S_MIN         = -(1 << (bqc_pkg::SAMPLE_W - 1));
    localparam int SLOT_TOP      = (1 << bqc_pkg::SLOT_W) - 1;
    localparam int SEC_TOP       = (1 << bqc_pkg::SEC_FIELD_W) - 1;
    localparam int NSEC_TOP      = (1 << bqc_pkg::NSEC_W) - 1;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    bqc_pkg::item_t             item         = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    bqc_pkg::result_t           result;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [bqc_pkg::NSEC_W-1:0] cfg_data     = '0;
    int                         fails;
    int                         pending;

    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    int stall_left   = 0;
    int rx_cycle     = 0;
    int idle_cycles  = 0;

    biquad_cascade_filter_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    biquad_cascade_filter_chk u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending)
    );

    always #6 clk = ~clk;

    // Mostly no gap, some short ones, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic bqc_pkg::item_t coef_word(int sec, int slot, int val);
        bqc_pkg::item_t w;
        w.action       = bqc_pkg::ACT_COEF;
        w.sample_in    = bqc_pkg::SAMPLE_W'($urandom);
        w.block_end    = 1'($urandom);
        w.coef_section = bqc_pkg::SEC_FIELD_W'(sec);
        w.coef_slot    = bqc_pkg::SLOT_W'(slot);
        w.coef_value   = bqc_pkg::COEF_W'(val);
        return w;
    endfunction

    function automatic bqc_pkg::item_t sample_word(int s, bit last);
        bqc_pkg::item_t w;
        w.action       = bqc_pkg::ACT_FILTER;
        w.sample_in    = bqc_pkg::SAMPLE_W'(s);
        w.block_end    = last;
        w.coef_section = bqc_pkg::SEC_FIELD_W'($urandom);
        w.coef_slot    = bqc_pkg::SLOT_W'($urandom);
        w.coef_value   = bqc_pkg::COEF_W'($urandom);
        return w;
    endfunction

    function automatic int pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return int'($urandom_range(16382)) - 8191;
        if (r < 80)
            return int'($urandom_range(65535)) + S_MIN;
        if (r < 90)
            return int'($urandom_range(32)) - 16;
        case ($urandom_range(3))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // Each call starts at a falling edge and returns at the accepting edge.
    task automatic send_word(input bqc_pkg::item_t w);
        int g;
        g = tx_quiet ? 0 : gap_len();
        @(negedge clk);
        if (g > 0)
        begin
            item_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_sections(input int n);
        @(negedge clk);
        cfg_data  <= bqc_pkg::NSEC_W'(n);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Loosely stable section most of the time; now and then raw words.
    task automatic program_section(input int sec, input bit wild);
        int a1, a2, lim, slot;
        a2  = int'($urandom_range(2 * 838861)) - 838861;
        lim = ((Q_ONE + a2) * 9) / 10;
        a1  = int'($urandom_range(2 * lim)) - lim;
        for (slot = int'(bqc_pkg::SLOT_B0); slot <= int'(bqc_pkg::SLOT_A2); slot++)
        begin
            if (wild)
                send_word(coef_word(sec, slot, $urandom));
            else if (slot == int'(bqc_pkg::SLOT_A1))
                send_word(coef_word(sec, slot, a1));
            else if (slot == int'(bqc_pkg::SLOT_A2))
                send_word(coef_word(sec, slot, a2));
            else
                send_word(coef_word(sec, slot, int'($urandom_range(2 * Q_ONE)) - Q_ONE));
        end
    endtask

    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 700 == 0)
            rx_quiet <= ($urandom_range(3) == 0);
    end

    always @(negedge clk)
    begin
        if (!rst_n || rx_quiet)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(2) == 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= gap_len();
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int p, i, r, pause_at, sec;
        int cfg_plan [NUM_PHASES];

        cfg_plan = '{0, NSEC_TOP, bqc_pkg::DEF_MAX_SECTIONS, 1, 2, 0, 0, 0, 0, 0};
        for (p = 5; p < NUM_PHASES; p++)
            cfg_plan[p] = $urandom_range(NSEC_TOP);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: one section, zero coefficients after reset.
        tx_quiet = 1'b1;
        send_word(sample_word(S_MAX, 1'b0));
        send_word(coef_word(0, int'(bqc_pkg::SLOT_B0), Q_ONE));
        send_word(sample_word(S_MIN, 1'b1));
        send_word(sample_word(S_MAX, 1'b0));
        // nonexistent slots: ignored
        send_word(coef_word(0, bqc_pkg::SLOTS, C_MAX));
        send_word(coef_word(SEC_TOP, SLOT_TOP, -1));
        send_word(sample_word(1, 1'b0));
        // half gain: rounding on both signs
        send_word(coef_word(0, int'(bqc_pkg::SLOT_B0), Q_ONE / 2));
        send_word(sample_word(1, 1'b0));
        send_word(sample_word(-1, 1'b1));
        send_word(sample_word(-3, 1'b0));
        send_word(coef_word(0, int'(bqc_pkg::SLOT_B0), C_MAX));
        send_word(sample_word(S_MAX, 1'b0));
        send_word(sample_word(S_MIN, 1'b0));
        // heavy feedback drives the state into saturation
        send_word(coef_word(0, int'(bqc_pkg::SLOT_A1), C_MIN));
        send_word(sample_word(S_MAX, 1'b0));
        send_word(sample_word(S_MAX, 1'b1));
        send_word(coef_word(0, int'(bqc_pkg::SLOT_B1), C_MIN));
        send_word(coef_word(0, int'(bqc_pkg::SLOT_B2), Q_ONE));
        send_word(coef_word(0, int'(bqc_pkg::SLOT_A2), C_MAX));
        send_word(sample_word(S_MIN, 1'b0));
        send_word(sample_word(0, 1'b0));
        send_word(sample_word(12345, 1'b1));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            set_sections(cfg_plan[p]);
            tx_quiet = ($urandom_range(3) == 0);
            for (sec = 0; sec < bqc_pkg::DEF_MAX_SECTIONS; sec++)
                program_section(sec, $urandom_range(7) == 0);
            pause_at = $urandom_range(SAMPLES_PHASE - 1);
            for (i = 0; i < SAMPLES_PHASE; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                r = $urandom_range(99);
                // stray coefficient words, some to slots that do not exist
                if (r < 5)
                    send_word(coef_word($urandom_range(SEC_TOP), $urandom_range(SLOT_TOP),
                                        $urandom));
                send_word(sample_word(pick_sample(), $urandom_range(7) == 0));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
